/* design/lwfri_pkg.sv */
// Shared constants and types for the lidar window filter with radial inflation.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lwfri_pkg;

	// fraction bits added to the ray length by the square root
	localparam int LEN_FRAC   = 12;
	localparam int INT_BITS   = 16;
	localparam int STEP_BITS  = 12;
	localparam int COUNT_BITS = 5;
	// quotient bits of 2*|c|*step*4096 / Lq, which never exceeds 2*step
	localparam int QUO_BITS   = STEP_BITS + 2;
	localparam int IDX_BITS   = 3;

	// configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_X_UPPER = 3'd0,
		REG_X_LOWER = 3'd1,
		REG_SIDE    = 3'd2,
		REG_THR     = 3'd3,
		REG_STEP    = 3'd4,
		REG_COUNT   = 3'd5
	} cfg_idx_t;

	// back end sequencer
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_PREP = 4'b0100,
		ST_EMIT = 4'b1000
	} back_st_t;

endpackage

`default_nettype wire

/* design/lwfri_front.sv */
// Front end: window filter, count clamp and a two-entry queue of kept points.
// Depends on lwfri_pkg.
`default_nettype none

module lwfri_front #(
	parameter int COORD_BITS    = 18,
	parameter int MAX_INFLATION = 16,
	localparam int NW = $clog2(MAX_INFLATION + 1)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [COORD_BITS-1:0]       in_x,
	input  wire logic signed [COORD_BITS-1:0]       in_y,
	input  wire logic [lwfri_pkg::INT_BITS-1:0]     in_inten,
	input  wire logic signed [COORD_BITS-1:0]       x_upper,
	input  wire logic signed [COORD_BITS-1:0]       x_lower,
	input  wire logic [COORD_BITS-2:0]              side,
	input  wire logic [lwfri_pkg::INT_BITS-1:0]     thr,
	input  wire logic [lwfri_pkg::COUNT_BITS-1:0]   count,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [COORD_BITS-1:0]            out_x,
	output logic signed [COORD_BITS-1:0]            out_y,
	output logic [lwfri_pkg::INT_BITS-1:0]          out_inten,
	output logic [NW-1:0]                           out_n,
	output logic [NW-1:0]                           out_off
);

	logic [COORD_BITS-1:0] ay;
	logic [NW-1:0]         n;
	logic [NW-1:0]         off;
	logic                  keep;
	logic                  push;
	logic                  pop;

	logic signed [COORD_BITS-1:0]        ent_x_q   [2];
	logic signed [COORD_BITS-1:0]        ent_y_q   [2];
	logic [lwfri_pkg::INT_BITS-1:0]      ent_int_q [2];
	logic [NW-1:0]                       ent_n_q   [2];
	logic [NW-1:0]                       ent_off_q [2];
	logic                                wr_ptr_q;
	logic                                rd_ptr_q;
	logic [1:0]                          cnt_q;

	// classify: window test and clamped run length
	always_comb begin
		ay = in_y[COORD_BITS-1] ? (~in_y + 1'b1) : in_y;
		if (int'(count) > MAX_INFLATION) begin
			n = NW'(MAX_INFLATION);
		end else begin
			n = NW'(count);
		end
		off  = (n - NW'(1)) >> 1;
		keep = (in_x > x_lower) && (in_x < x_upper) && (ay < {1'b0, side})
			&& (in_inten > thr) && (n != '0);
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready && keep;
	assign pop       = out_valid && out_ready;

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// store kept points
	always_ff @(posedge clk) begin
		if (push) begin
			ent_x_q[wr_ptr_q]   <= in_x;
			ent_y_q[wr_ptr_q]   <= in_y;
			ent_int_q[wr_ptr_q] <= in_inten;
			ent_n_q[wr_ptr_q]   <= n;
			ent_off_q[wr_ptr_q] <= off;
		end
	end

	assign out_x     = ent_x_q[rd_ptr_q];
	assign out_y     = ent_y_q[rd_ptr_q];
	assign out_inten = ent_int_q[rd_ptr_q];
	assign out_n     = ent_n_q[rd_ptr_q];
	assign out_off   = ent_off_q[rd_ptr_q];

endmodule

`default_nettype wire

/* design/lwfri_root.sv */
// Bit-serial square root: Lq = floor(sqrt((x^2 + y^2) * 2^24)), one root bit per cycle.
// Depends on lwfri_pkg.
`default_nettype none

module lwfri_root #(
	parameter int COORD_BITS    = 18,
	parameter int MAX_INFLATION = 16,
	localparam int NW = $clog2(MAX_INFLATION + 1),
	localparam int LW = COORD_BITS + lwfri_pkg::LEN_FRAC
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [COORD_BITS-1:0]   in_x,
	input  wire logic signed [COORD_BITS-1:0]   in_y,
	input  wire logic [lwfri_pkg::INT_BITS-1:0] in_inten,
	input  wire logic [NW-1:0]                  in_n,
	input  wire logic [NW-1:0]                  in_off,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [COORD_BITS-1:0]        out_x,
	output logic signed [COORD_BITS-1:0]        out_y,
	output logic [lwfri_pkg::INT_BITS-1:0]      out_inten,
	output logic [NW-1:0]                       out_n,
	output logic [NW-1:0]                       out_off,
	output logic [LW-1:0]                       out_lq
);

	localparam int RC = $clog2(LW + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [RC-1:0]          cnt_q;
	logic [2*LW-1:0]        rad_q;
	logic [LW+1:0]          rem_q;
	logic [LW-1:0]          root_q;
	logic signed [COORD_BITS-1:0]   x_q;
	logic signed [COORD_BITS-1:0]   y_q;
	logic [lwfri_pkg::INT_BITS-1:0] int_q;
	logic [NW-1:0]          n_q;
	logic [NW-1:0]          off_q;

	logic                   acc;
	logic signed [2*COORD_BITS-1:0] xx;
	logic signed [2*COORD_BITS-1:0] yy;
	logic [2*COORD_BITS-1:0] s;
	logic [LW+1:0]          rem_sh;
	logic [LW+1:0]          trial;
	logic                   ge;

	assign in_ready = !busy_q && (!done_q || out_ready);
	assign acc      = in_valid && in_ready;

	// squared length and one digit step of the root
	always_comb begin
		xx     = (2*COORD_BITS)'(in_x) * (2*COORD_BITS)'(in_x);
		yy     = (2*COORD_BITS)'(in_y) * (2*COORD_BITS)'(in_y);
		s      = xx + yy;
		rem_sh = {rem_q[LW-1:0], rad_q[2*LW-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = (rem_sh >= trial);
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (acc) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= RC'(LW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - RC'(1);
			if (cnt_q == RC'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (out_ready) begin
			done_q <= 1'b0;
		end
	end

	// load the radicand, then shift out two bits per cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			rad_q  <= {s, {(2*lwfri_pkg::LEN_FRAC){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
			x_q    <= in_x;
			y_q    <= in_y;
			int_q  <= in_inten;
			n_q    <= in_n;
			off_q  <= in_off;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[LW-2:0], ge};
		end
	end

	assign out_valid = done_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_inten = int_q;
	assign out_n     = n_q;
	assign out_off   = off_q;
	assign out_lq    = root_q;

endmodule

`default_nettype wire

/* design/lwfri_back.sv */
// Back end: per-coordinate division by Lq, incremental walk over the run, rounding,
// saturation and the output register. Depends on lwfri_pkg.
`default_nettype none

module lwfri_back #(
	parameter int COORD_BITS    = 18,
	parameter int MAX_INFLATION = 16,
	localparam int NW = $clog2(MAX_INFLATION + 1),
	localparam int LW = COORD_BITS + lwfri_pkg::LEN_FRAC
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [COORD_BITS-1:0]    in_x,
	input  wire logic signed [COORD_BITS-1:0]    in_y,
	input  wire logic [lwfri_pkg::INT_BITS-1:0]  in_inten,
	input  wire logic [NW-1:0]                   in_n,
	input  wire logic [NW-1:0]                   in_off,
	input  wire logic [LW-1:0]                   in_lq,
	input  wire logic [lwfri_pkg::STEP_BITS-1:0] step,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [COORD_BITS-1:0]                out_x,
	output logic [COORD_BITS-1:0]                out_y,
	output logic [lwfri_pkg::INT_BITS-1:0]       out_inten,
	output logic                                 out_last
);

	localparam int QB = lwfri_pkg::QUO_BITS;
	localparam int SB = lwfri_pkg::STEP_BITS;
	localparam int MW = COORD_BITS + SB + lwfri_pkg::LEN_FRAC + 1;
	localparam int GW = QB + NW;
	localparam int SW = COORD_BITS + GW + 1;
	localparam int DC = $clog2(QB);

	lwfri_pkg::back_st_t st_q;
	logic [DC-1:0]       dcnt_q;
	logic [NW-1:0]       i_q;
	logic [NW-1:0]       absk_q;
	logic                ov_q;

	logic signed [COORD_BITS-1:0]   x_q;
	logic signed [COORD_BITS-1:0]   y_q;
	logic [lwfri_pkg::INT_BITS-1:0] int_q;
	logic [NW-1:0]       n_q;
	logic [NW-1:0]       off_q;
	logic [LW-1:0]       lq_q;
	logic [MW-1:0]       mx_q;
	logic [MW-1:0]       my_q;
	logic [MW-1:0]       dv_q;
	logic [QB-1:0]       qx_q;
	logic [QB-1:0]       qy_q;
	logic [GW-1:0]       gx_q;
	logic [GW-1:0]       gy_q;
	logic [LW-1:0]       rx_q;
	logic [LW-1:0]       ry_q;
	logic [COORD_BITS-1:0]          ox_q;
	logic [COORD_BITS-1:0]          oy_q;
	logic [lwfri_pkg::INT_BITS-1:0] oint_q;
	logic                           olast_q;

	logic                acc;
	logic                last;
	logic                emit_fire;
	logic                kneg;
	logic                lqz;
	logic                walk_up;
	logic [COORD_BITS-1:0]    ax;
	logic [COORD_BITS-1:0]    ay;
	logic [COORD_BITS+SB-1:0] px;
	logic [COORD_BITS+SB-1:0] py;
	logic [GW+LW-1:0]    wx;
	logic [GW+LW-1:0]    wy;
	logic [GW:0]         gx1;
	logic [GW:0]         gy1;
	logic [NW+SB-1:0]    kstep;
	logic [GW-1:0]       qxv;
	logic [GW-1:0]       qyv;
	logic                negx;
	logic                negy;
	logic signed [SW-1:0] cx;
	logic signed [SW-1:0] cy;
	logic signed [SW-1:0] vx;
	logic signed [SW-1:0] vy;
	logic [COORD_BITS-1:0] sx;
	logic [COORD_BITS-1:0] sy;

	// one step of floor(|k| * M / Lq) with its remainder, up or down by one in |k|
	function automatic logic [GW+LW-1:0] walk(input logic [GW-1:0] g, input logic [LW-1:0] r,
		input logic [QB-1:0] qm, input logic [LW-1:0] rm, input logic [LW-1:0] lq,
		input logic up);
		logic [LW:0]   t;
		logic [GW-1:0] gq;
		gq = GW'(qm);
		if (up) begin
			t = {1'b0, r} + {1'b0, rm};
			if (t >= {1'b0, lq}) walk = {g + gq + GW'(1), LW'(t - {1'b0, lq})};
			else walk = {g + gq, t[LW-1:0]};
		end else begin
			t = {1'b0, r} - {1'b0, rm};
			if (t[LW]) walk = {g - gq - GW'(1), LW'(t + {1'b0, lq})};
			else walk = {g - gq, t[LW-1:0]};
		end
	endfunction

	// clamp to the signed coordinate range
	function automatic logic [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
		logic [SW-COORD_BITS:0] top;
		top = v[SW-1:COORD_BITS-1];
		if (top == '0 || top == '1) sat = v[COORD_BITS-1:0];
		else if (v[SW-1]) sat = {1'b1, {(COORD_BITS-1){1'b0}}};
		else sat = {1'b0, {(COORD_BITS-1){1'b1}}};
	endfunction

	assign last      = (i_q == n_q - NW'(1));
	assign emit_fire = (st_q == lwfri_pkg::ST_EMIT) && (!ov_q || out_ready);
	assign in_ready  = (st_q == lwfri_pkg::ST_IDLE) || (emit_fire && last);
	assign acc       = in_valid && in_ready;

	// dividends, walk step and rounded, saturated coordinates
	always_comb begin
		ax      = in_x[COORD_BITS-1] ? (~in_x + 1'b1) : in_x;
		ay      = in_y[COORD_BITS-1] ? (~in_y + 1'b1) : in_y;
		px      = (COORD_BITS+SB)'(ax) * (COORD_BITS+SB)'(step);
		py      = (COORD_BITS+SB)'(ay) * (COORD_BITS+SB)'(step);
		kneg    = (i_q < off_q);
		walk_up = (st_q == lwfri_pkg::ST_PREP) || !kneg;
		wx      = walk(gx_q, rx_q, qx_q, mx_q[LW-1:0], lq_q, walk_up);
		wy      = walk(gy_q, ry_q, qy_q, my_q[LW-1:0], lq_q, walk_up);
		lqz     = (lq_q == '0);
		gx1     = {1'b0, gx_q} + (GW+1)'(1);
		gy1     = {1'b0, gy_q} + (GW+1)'(1);
		kstep   = (NW+SB)'(absk_q) * (NW+SB)'(step);
		qxv     = gx1[GW:1];
		qyv     = lqz ? GW'(kstep) : gy1[GW:1];
		negx    = x_q[COORD_BITS-1] ^ kneg;
		negy    = lqz ? kneg : (y_q[COORD_BITS-1] ^ kneg);
		cx      = SW'(x_q);
		cy      = lqz ? '0 : SW'(y_q);
		vx      = negx ? (cx - SW'(qxv)) : (cx + SW'(qxv));
		vy      = negy ? (cy - SW'(qyv)) : (cy + SW'(qyv));
		sx      = lqz ? '0 : sat(vx);
		sy      = sat(vy);
	end

	// sequencer, run position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= lwfri_pkg::ST_IDLE;
			dcnt_q <= '0;
			i_q    <= '0;
			absk_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (emit_fire) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;

			if (acc) begin
				st_q   <= (in_lq == '0) ? lwfri_pkg::ST_EMIT : lwfri_pkg::ST_DIV;
				dcnt_q <= DC'(QB - 1);
				i_q    <= '0;
				absk_q <= (in_lq == '0) ? in_off : '0;
			end else begin
				case (st_q)
					lwfri_pkg::ST_DIV: begin
						dcnt_q <= dcnt_q - DC'(1);
						if (dcnt_q == '0) begin
							st_q <= (off_q == '0) ? lwfri_pkg::ST_EMIT : lwfri_pkg::ST_PREP;
						end
					end
					lwfri_pkg::ST_PREP: begin
						absk_q <= absk_q + NW'(1);
						if (absk_q + NW'(1) == off_q) st_q <= lwfri_pkg::ST_EMIT;
					end
					lwfri_pkg::ST_EMIT: begin
						if (emit_fire) begin
							i_q    <= i_q + NW'(1);
							absk_q <= kneg ? (absk_q - NW'(1)) : (absk_q + NW'(1));
							if (last) st_q <= lwfri_pkg::ST_IDLE;
						end
					end
					default: begin
						st_q <= lwfri_pkg::ST_IDLE;
					end
				endcase
			end
		end
	end

	// datapath: divide, walk to the first point, walk along the run
	always_ff @(posedge clk) begin
		if (acc) begin
			x_q   <= in_x;
			y_q   <= in_y;
			int_q <= in_inten;
			n_q   <= in_n;
			off_q <= in_off;
			lq_q  <= in_lq;
			mx_q  <= MW'(px) << (lwfri_pkg::LEN_FRAC + 1);
			my_q  <= MW'(py) << (lwfri_pkg::LEN_FRAC + 1);
			dv_q  <= MW'(in_lq) << (QB - 1);
			gx_q  <= '0;
			gy_q  <= '0;
			rx_q  <= '0;
			ry_q  <= '0;
		end else if (st_q == lwfri_pkg::ST_DIV) begin
			if (mx_q >= dv_q) mx_q <= mx_q - dv_q;
			if (my_q >= dv_q) my_q <= my_q - dv_q;
			qx_q <= {qx_q[QB-2:0], (mx_q >= dv_q)};
			qy_q <= {qy_q[QB-2:0], (my_q >= dv_q)};
			dv_q <= dv_q >> 1;
		end else if ((st_q == lwfri_pkg::ST_PREP) || emit_fire) begin
			{gx_q, rx_q} <= wx;
			{gy_q, ry_q} <= wy;
		end

		if (emit_fire) begin
			ox_q    <= sx;
			oy_q    <= sy;
			oint_q  <= int_q;
			olast_q <= last;
		end
	end

	assign out_valid = ov_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_inten = oint_q;
	assign out_last  = olast_q;

endmodule

`default_nettype wire

/* design/lidar_window_filter_radial_inflate_top.sv */
// Top level of the lidar window filter with radial inflation: configuration
// registers, stream packing and the front, root and back units. Depends on lwfri_pkg.
//
// Usage: points enter on the s_ channel (tdata: x, y, intensity), results leave on
// the m_ channel (tdata: x, y, intensity; tlast marks the last point of a run).
// A point outside the window, at or below the intensity threshold, or with a run
// length of zero yields nothing and never enters the front queue. A kept point yields a
// run of min(inflation_count, MAX_INFLATION) points along its ray.
// A kept point passes through the front queue, the square root, the division (skipped
// when Lq is zero), off = (n-1)/2 walk steps and the output register. The square root
// runs alongside the back end and can take the next kept point while a run is walked.
// Results leave one per cycle within a run while m_tready stays high.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while the block is idle. The block itself does not enforce this.
// Reset clears all queues and loads the register defaults. A stall on m_tready
// holds the output register; the back end, root unit and front queue fill in turn
// and s_tready falls once the two-entry queue is full.
`default_nettype none

module lidar_window_filter_radial_inflate_top #(
	parameter int MAX_INFLATION = 16,
	parameter int COORD_BITS    = 18
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// point_x, point_y, point_intensity, zero fill
	input  wire logic [((2*COORD_BITS+lwfri_pkg::INT_BITS+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// out_x, out_y, out_intensity, zero fill
	output logic [((2*COORD_BITS+lwfri_pkg::INT_BITS+7)/8)*8-1:0] m_tdata,
	output logic      m_tlast,
	input  wire logic cfg_we,
	input  wire logic [lwfri_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [((COORD_BITS > lwfri_pkg::INT_BITS) ? COORD_BITS
		: lwfri_pkg::INT_BITS)-1:0] cfg_wdata
);

	localparam int NW  = $clog2(MAX_INFLATION + 1);
	localparam int LW  = COORD_BITS + lwfri_pkg::LEN_FRAC;
	localparam int DW  = ((2*COORD_BITS + lwfri_pkg::INT_BITS + 7) / 8) * 8;
	localparam int IB  = lwfri_pkg::INT_BITS;

	logic signed [COORD_BITS-1:0]           x_upper_q;
	logic signed [COORD_BITS-1:0]           x_lower_q;
	logic [COORD_BITS-2:0]                  side_q;
	logic [IB-1:0]                          thr_q;
	logic [lwfri_pkg::STEP_BITS-1:0]        step_q;
	logic [lwfri_pkg::COUNT_BITS-1:0]       count_q;

	logic signed [COORD_BITS-1:0] f_x, f_y, r_x, r_y;
	logic [IB-1:0]                f_int, r_int;
	logic [NW-1:0]                f_n, f_off, r_n, r_off;
	logic                         f_valid, f_ready, r_valid, r_ready;
	logic [LW-1:0]                r_lq;
	logic [COORD_BITS-1:0]        o_x, o_y;
	logic [IB-1:0]                o_int;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_upper_q <= COORD_BITS'(8192);
			x_lower_q <= COORD_BITS'(-4096);
			side_q    <= (COORD_BITS-1)'(4096);
			thr_q     <= IB'(30000);
			step_q    <= lwfri_pkg::STEP_BITS'(20);
			count_q   <= lwfri_pkg::COUNT_BITS'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				lwfri_pkg::REG_X_UPPER: x_upper_q <= cfg_wdata[COORD_BITS-1:0];
				lwfri_pkg::REG_X_LOWER: x_lower_q <= cfg_wdata[COORD_BITS-1:0];
				lwfri_pkg::REG_SIDE:    side_q    <= cfg_wdata[COORD_BITS-2:0];
				lwfri_pkg::REG_THR:     thr_q     <= cfg_wdata[IB-1:0];
				lwfri_pkg::REG_STEP:    step_q    <= cfg_wdata[lwfri_pkg::STEP_BITS-1:0];
				lwfri_pkg::REG_COUNT:   count_q   <= cfg_wdata[lwfri_pkg::COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	lwfri_front #(
		.COORD_BITS(COORD_BITS),
		.MAX_INFLATION(MAX_INFLATION)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_x(s_tdata[COORD_BITS-1:0]),
		.in_y(s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.in_inten(s_tdata[2*COORD_BITS+IB-1:2*COORD_BITS]),
		.x_upper(x_upper_q),
		.x_lower(x_lower_q),
		.side(side_q),
		.thr(thr_q),
		.count(count_q),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_x(f_x),
		.out_y(f_y),
		.out_inten(f_int),
		.out_n(f_n),
		.out_off(f_off)
	);

	lwfri_root #(
		.COORD_BITS(COORD_BITS),
		.MAX_INFLATION(MAX_INFLATION)
	) u_root (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(f_valid),
		.in_ready(f_ready),
		.in_x(f_x),
		.in_y(f_y),
		.in_inten(f_int),
		.in_n(f_n),
		.in_off(f_off),
		.out_valid(r_valid),
		.out_ready(r_ready),
		.out_x(r_x),
		.out_y(r_y),
		.out_inten(r_int),
		.out_n(r_n),
		.out_off(r_off),
		.out_lq(r_lq)
	);

	lwfri_back #(
		.COORD_BITS(COORD_BITS),
		.MAX_INFLATION(MAX_INFLATION)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(r_valid),
		.in_ready(r_ready),
		.in_x(r_x),
		.in_y(r_y),
		.in_inten(r_int),
		.in_n(r_n),
		.in_off(r_off),
		.in_lq(r_lq),
		.step(step_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_x(o_x),
		.out_y(o_y),
		.out_inten(o_int),
		.out_last(m_tlast)
	);

	// pack results, zero fill above
	assign m_tdata = DW'({o_int, o_y, o_x});

endmodule

`default_nettype wire

/* tb/sv/lidar_window_filter_radial_inflate_checker.sv */
// Checker for the lidar window filter with radial inflation: tracks register writes,
// predicts the inflated points of every accepted input and compares the output stream.
// Depends on lwfri_pkg.
`default_nettype none

module lidar_window_filter_radial_inflate_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// point_x, point_y, point_intensity, zero fill
	input  wire logic [55:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// out_x, out_y, out_intensity, zero fill
	input  wire logic [55:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [lwfri_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [17:0] cfg_wdata,
	output int               fails,
	output int               pending
);
	import lwfri_pkg::*;

	localparam int MAX_RUN = 16;
	localparam longint COORD_HI = 131071;
	localparam longint COORD_LO = -131072;

	typedef struct {
		logic signed [17:0] px;
		logic signed [17:0] py;
		logic [15:0]        inten;
		logic               last;
	} ray_point_t;

	ray_point_t ray_points_due[$];

	logic signed [17:0] x_upper, x_lower;
	logic [16:0]        side;
	logic [15:0]        thr;
	logic [11:0]        step;
	logic [4:0]         count;

	assign pending = ray_points_due.size();

	// floor(sqrt(s * 2^24)), bit by bit
	function automatic longint unsigned ray_len_q12(longint unsigned s);
		longint unsigned v, root, bitv;
		v = s << 24;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_HI) return COORD_HI;
		if (v < COORD_LO) return COORD_LO;
		return v;
	endfunction

	// c + round(c * d / lq), ties away from zero
	function automatic longint stretch_coord(longint c, longint d, longint unsigned lq);
		longint num;
		longint unsigned mag, q;
		num = c * d;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (2 * mag + lq) / (2 * lq);
		return clamp_coord((num < 0) ? c - longint'(q) : c + longint'(q));
	endfunction

	// filter one point and queue its run of inflated points
	task automatic predict_run(logic signed [17:0] px, logic signed [17:0] py,
			logic [15:0] inten);
		longint x, y, ay, k, d;
		longint unsigned lq;
		int n, off;
		ray_point_t rp;
		x = px;
		y = py;
		ay = (y < 0) ? -y : y;
		if (!(x > longint'(x_lower) && x < longint'(x_upper) && ay < longint'(side)
				&& inten > thr))
			return;
		n = (count > MAX_RUN) ? MAX_RUN : int'(count);
		off = (n - 1) / 2;
		lq = ray_len_q12(longint'(x * x + y * y));
		for (int i = 0; i < n; i++) begin
			k = i - off;
			if (lq == 0) begin
				rp.px = '0;
				rp.py = 18'(clamp_coord(k * longint'(step)));
			end else begin
				d = k * longint'(step) * 4096;
				rp.px = 18'(stretch_coord(x, d, lq));
				rp.py = 18'(stretch_coord(y, d, lq));
			end
			rp.inten = inten;
			rp.last = (i == n - 1);
			ray_points_due.insert(ray_points_due.size(), rp);
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		fails++;
	endtask

	initial fails = 0;

	// follow registers, predict on input items, compare output items
	always @(posedge clk or negedge arst_n) begin
		ray_point_t want;
		if (!arst_n) begin
			x_upper <= 18'sd8192;
			x_lower <= -18'sd4096;
			side    <= 17'd4096;
			thr     <= 16'd30000;
			step    <= 12'd20;
			count   <= 5'd5;
			ray_points_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				predict_run(s_tdata[17:0], s_tdata[35:18], s_tdata[51:36]);
			if (m_tvalid && m_tready) begin
				if (ray_points_due.size() == 0) begin
					$display("unexpected output item x=%0d y=%0d",
						$signed(m_tdata[17:0]), $signed(m_tdata[35:18]));
					fails++;
				end else begin
					want = ray_points_due.pop_front();
					if ($signed(m_tdata[17:0]) != want.px)
						report("out_x", $signed(m_tdata[17:0]), want.px);
					if ($signed(m_tdata[35:18]) != want.py)
						report("out_y", $signed(m_tdata[35:18]), want.py);
					if (m_tdata[51:36] != want.inten)
						report("out_intensity", m_tdata[51:36], want.inten);
					if (m_tdata[55:52] != 4'd0)
						report("tdata fill", m_tdata[55:52], 0);
					if (m_tlast != want.last)
						report("run_last", m_tlast, want.last);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_X_UPPER: x_upper <= cfg_wdata;
					REG_X_LOWER: x_lower <= cfg_wdata;
					REG_SIDE:    side    <= cfg_wdata[16:0];
					REG_THR:     thr     <= cfg_wdata[15:0];
					REG_STEP:    step    <= cfg_wdata[11:0];
					REG_COUNT:   count   <= cfg_wdata[4:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* tb/sv/lidar_window_filter_radial_inflate_top_test.sv */
// Testbench top for the lidar window filter with radial inflation: clock, reset,
// register setup, point stimulus and the verdict. Depends on lwfri_pkg and the checker.
`default_nettype none

module lidar_window_filter_radial_inflate_top_test;
	import lwfri_pkg::*;

	localparam logic [IDX_BITS-1:0] IDX_UNUSED_LO = 3'd6;
	localparam logic [IDX_BITS-1:0] IDX_UNUSED_HI = 3'd7;
	localparam int SETTLE = 80;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready;
	logic [55:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0, m_tlast;
	logic [55:0] m_tdata;
	logic cfg_we = 0;
	logic [IDX_BITS-1:0] cfg_index = REG_X_UPPER;
	logic [17:0] cfg_wdata = '0;
	int fails, pending;
	int cycles = 0;
	int ready_pct = 100;
	int burst_left = 0;

	// shadow of the window registers for shaping random points
	int win_up = 8192, win_down = -4096, win_side = 4096, win_thr = 30000;

	lidar_window_filter_radial_inflate_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	lidar_window_filter_radial_inflate_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fails(fails), .pending(pending)
	);

	always #4 clk = ~clk;

	// stall the output at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) < ready_pct);
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_BITS-1:0] idx, int value);
		// drop the input while registers change
		s_tvalid <= 1'b0;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[17:0];
		case (idx)
			REG_X_UPPER: win_up = value;
			REG_X_LOWER: win_down = value;
			REG_SIDE:    win_side = value;
			REG_THR:     win_thr = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold input until the block has emitted everything and gone quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// offer one point, advance on acceptance, then idle between bursts
	task automatic send_point(int x, int y, int inten);
		logic rdy;
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, inten[15:0], y[17:0], x[17:0]};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// mostly points inside the window, some drawn from the whole field range
	task automatic send_random_point();
		int x, y, inten;
		x = $signed(18'($urandom()));
		y = $signed(18'($urandom()));
		inten = $urandom_range(0, 65535);
		if ($urandom_range(0, 9) < 7) begin
			if (win_up - win_down > 1)
				x = win_down + 1 + $urandom_range(0, win_up - win_down - 2);
			if (win_side > 0)
				y = $urandom_range(0, 2 * win_side - 2) - (win_side - 1);
			if (win_thr < 65535)
				inten = win_thr + 1 + $urandom_range(0, 65534 - win_thr);
		end
		send_point(x, y, inten);
	endtask

	task automatic open_window();
		write_reg(REG_X_UPPER, 131071);
		write_reg(REG_X_LOWER, -131072);
		write_reg(REG_SIDE, 131071);
		write_reg(REG_THR, 0);
	endtask

	initial begin
		int steps[4];
		int counts[5];
		int lo, hi;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults, inside and outside the window
		send_point(100, 50, 40000);
		send_point(8192, 0, 40000);
		send_point(100, 4096, 40000);
		send_point(100, -50, 30000);
		drain();

		// wide window: field extremes, zero length, negative radius
		open_window();
		write_reg(REG_STEP, 4095);
		write_reg(REG_COUNT, 16);
		send_point(0, 0, 1);
		send_point(131070, 131070, 65535);
		send_point(-131071, -131070, 1);
		send_point(131070, -131070, 32768);
		send_point(3, 4, 7);
		send_point(0, 0, 0);
		drain();

		// count above range, zero count, one point, zero step
		write_reg(REG_COUNT, 31);
		send_point(-5, 2, 9);
		drain();
		write_reg(REG_COUNT, 0);
		send_point(1000, 1000, 9);
		drain();
		write_reg(REG_COUNT, 1);
		write_reg(REG_STEP, 0);
		send_point(-77, 123, 9);
		send_point(0, 0, 9);
		drain();

		// writes to unused indexes leave registers alone
		write_reg(IDX_UNUSED_LO, 0);
		write_reg(IDX_UNUSED_HI, 131071);
		send_point(500, -700, 100);
		drain();

		// threshold at top rejects everything; tight window edges
		write_reg(REG_THR, 65535);
		send_point(10, 10, 65535);
		write_reg(REG_THR, 0);
		write_reg(REG_SIDE, 0);
		send_point(10, 0, 5);
		write_reg(REG_SIDE, 1);
		write_reg(REG_X_UPPER, -131071);
		write_reg(REG_X_LOWER, -131072);
		send_point(-131072, 0, 5);
		drain();

		// random phases with varied registers and output stall rates
		steps = '{0, 4095, 20, 0};
		counts = '{16, 31, 1, 0, 5};
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			steps[3] = $urandom_range(0, 4095);
			counts[3] = $urandom_range(2, 8);
			lo = -$urandom_range(0, 131072);
			hi = (ph % 2 == 0) ? 131071 : lo + 2 + $urandom_range(0, 131071 - lo - 2);
			write_reg(REG_X_LOWER, lo);
			write_reg(REG_X_UPPER, hi);
			write_reg(REG_SIDE, (ph == 0) ? 131071 : $urandom_range(1, 131071));
			write_reg(REG_THR, (ph == 1) ? 0 : $urandom_range(0, 65534));
			write_reg(REG_STEP, steps[$urandom_range(0, 3)]);
			write_reg(REG_COUNT, (ph < 5) ? counts[ph % 5] : counts[3]);
			ready_pct = (ph % 3 == 0) ? 100 : $urandom_range(20, 90);
			for (int n = 0; n < 56; n++) send_random_point();
		end

		drain();
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
